FILE: design/crop_window_smooth_tracker_assert.svh
// assertion macros shared by the checker of the crop tracker
`ifndef CROP_WINDOW_SMOOTH_TRACKER_ASSERT_SVH
`define CROP_WINDOW_SMOOTH_TRACKER_ASSERT_SVH

// same-cycle implication, off while in reset
`define CWST_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cwst: assertion failed");

// next-cycle implication, off while in reset
`define CWST_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cwst: assertion failed");

// next-cycle implication that also watches the reset itself
`define CWST_ASSERT_RST_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cwst: reset assertion failed");

`endif

FILE: design/cwst_pkg.sv
`default_nettype none
package cwst_pkg;

  localparam int POS_W      = 24;
  localparam int IN_W       = 21;
  localparam int STEP_W     = 14;
  localparam int SPEED_W    = 10;
  localparam int MAXSTEP_W  = 18;
  localparam int FWIDTH_W   = 14;
  localparam int MV_W       = 26;
  localparam int KEY_W      = 27;
  localparam int DIVIDEND_W = 48;
  localparam int DIVISOR_W  = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int LANES      = 3;
  localparam int LANE_W     = 2;

  localparam logic [POS_W-1:0]     POS_MAX     = 24'hFFFFFF;
  localparam logic [IN_W-1:0]      OUT_MAX     = 21'h1FFFFF;
  localparam logic [STEP_W-1:0]    STEP_MAX    = 14'd16383;
  localparam logic [SPEED_W-1:0]   SPEED_RST   = 10'd100;
  localparam logic [MAXSTEP_W-1:0] MAXSTEP_RST = 18'd5120;
  localparam logic [FWIDTH_W-1:0]  FWIDTH_RST  = 14'd3840;
  localparam logic [SPEED_W-1:0]   PERMILLE    = 10'd1000;
  localparam logic [STEP_W-1:0]    LIMIT_XY    = 14'd3;
  localparam logic [STEP_W-1:0]    LIMIT_W     = 14'd2;

  // axis indexes
  localparam logic [LANE_W-1:0] AXIS_X = 2'd0;
  localparam logic [LANE_W-1:0] AXIS_Y = 2'd1;
  localparam logic [LANE_W-1:0] AXIS_W = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W  = 2'd2;

  typedef logic [3:0] op_t;

  localparam op_t OP_NONE          = 4'd0;
  localparam op_t OP_LOAD          = 4'd1;
  localparam op_t OP_DIV_PATH      = 4'd2;
  localparam op_t OP_DMAX          = 4'd3;
  localparam op_t OP_DIV_EXTRA     = 4'd4;
  localparam op_t OP_ZERO_EXTRA    = 4'd5;
  localparam op_t OP_WORK_FROM_CUR = 4'd6;
  localparam op_t OP_DIV_MV        = 4'd7;
  localparam op_t OP_KEY           = 4'd8;
  localparam op_t OP_DIV_STEP      = 4'd9;
  localparam op_t OP_CUR_FROM_WORK = 4'd10;
  localparam op_t OP_ST_INIT       = 4'd11;
  localparam op_t OP_ST_AFTER      = 4'd12;
  localparam op_t OP_ST_DONE       = 4'd13;
  localparam op_t OP_SET_CAP       = 4'd14;
  localparam op_t OP_FINISH        = 4'd15;

  typedef struct packed {
    op_t               op;
    logic [LANE_W-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic dmax_zero;
    logic loop_go;
    logic ps_eq;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

FILE: design/cwst_div.sv
`default_nettype none
module cwst_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [cwst_pkg::DIVIDEND_W-1:0]  dividend,
  input  wire logic [cwst_pkg::DIVISOR_W-1:0]   divisor,
  output logic                                  done,
  output logic [cwst_pkg::DIVIDEND_W-1:0]       quotient
);

  localparam int DD_W  = cwst_pkg::DIVIDEND_W;
  localparam int DS_W  = cwst_pkg::DIVISOR_W;
  localparam int CNT_W = $clog2(DD_W + 1);

  logic [DS_W-1:0]  dvs;
  logic [DS_W-1:0]  rem;
  logic [DD_W-1:0]  quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DS_W:0]    trial;
  logic [DS_W:0]    diff;
  logic             fit;

  // restoring division, one quotient bit a cycle
  assign trial    = {rem, quo[DD_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign fit      = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fit ? diff[DS_W-1:0] : trial[DS_W-1:0];
      quo <= {quo[DD_W-2:0], fit};
    end
  end

endmodule
`default_nettype wire

FILE: design/cwst_dp.sv
`default_nettype none
module cwst_dp #(
  parameter int FRAC_BITS = 8,
  parameter int REF_WIDTH = 3840
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [cwst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cwst_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [cwst_pkg::IN_W-1:0]         in_x,
  input  wire logic [cwst_pkg::IN_W-1:0]         in_y,
  input  wire logic [cwst_pkg::IN_W-1:0]         in_w,
  input  wire cwst_pkg::cmd_t                    cmd,
  output cwst_pkg::status_t                      status,
  output logic [cwst_pkg::IN_W-1:0]              out_x,
  output logic [cwst_pkg::IN_W-1:0]              out_y,
  output logic [cwst_pkg::IN_W-1:0]              out_w,
  output logic                                   out_capped,
  output logic                                   out_valid,
  input  wire logic                              out_ready
);

  localparam int PW = cwst_pkg::POS_W;
  localparam int SW = cwst_pkg::STEP_W;
  localparam int NL = cwst_pkg::LANES;
  localparam logic [25:0]   PATH_K = 26'(800 << FRAC_BITS);
  localparam logic [13:0]   REF_W  = 14'(REF_WIDTH);
  localparam logic [PW-1:0] HALF3  = PW'(3 << (FRAC_BITS - 1));
  // ceil(2^35 / 125)
  localparam logic [28:0]   RECIP_125 = 29'h10624DD3;

  // configuration
  logic [cwst_pkg::SPEED_W-1:0]   speed;
  logic [cwst_pkg::MAXSTEP_W-1:0] max_step;
  logic [cwst_pkg::FWIDTH_W-1:0]  frame_w;

  // tracker state
  logic [PW-1:0] cur   [NL];
  logic [PW-1:0] tgt   [NL];
  logic [PW-1:0] prev  [NL];
  logic [PW-1:0] extra [NL];
  logic [SW-1:0] pstep [NL];
  logic          seen;
  logic          capped;

  // scratch
  logic [PW-1:0]               work [NL];
  logic [cwst_pkg::MV_W-1:0]   mv   [NL];
  logic [cwst_pkg::KEY_W-1:0]  key;
  logic [PW-1:0]               path;
  logic [PW-1:0]               dmax;
  logic [SW-1:0]               cs;
  logic [SW-1:0]               tmp;
  logic [PW:0]                 pos;
  cwst_pkg::op_t               div_op;

  function automatic logic [PW-1:0] abs24(input logic [PW-1:0] a, input logic [PW-1:0] b);
    abs24 = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [PW:0] abs25(input logic [PW:0] a, input logic [PW:0] b);
    abs25 = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [SW-1:0] abs14(input logic [SW-1:0] a, input logic [SW-1:0] b);
    abs14 = (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [PW:0] ceil_px(input logic [PW-1:0] v);
    ceil_px = ({1'b0, v} + (PW+1)'((1 << FRAC_BITS) - 1)) >> FRAC_BITS;
  endfunction

  function automatic logic [SW-1:0] sat_step(input logic [PW:0] v);
    sat_step = (v > (PW+1)'(cwst_pkg::STEP_MAX)) ? cwst_pkg::STEP_MAX : v[SW-1:0];
  endfunction

  // move c by px whole pixels, toward or away from t
  function automatic logic [PW-1:0] nudge(input logic [PW-1:0] c, input logic [PW-1:0] t,
                                          input logic [SW-1:0] px, input logic toward);
    logic        up;
    logic [31:0] d;
    logic [31:0] s;
    up = (t > c) ^ ~toward;
    d  = 32'(px) << FRAC_BITS;
    s  = 32'(c) + d;
    if (up) begin
      nudge = (s > 32'(cwst_pkg::POS_MAX)) ? cwst_pkg::POS_MAX : s[PW-1:0];
    end else begin
      nudge = (32'(c) >= d) ? PW'(32'(c) - d) : '0;
    end
  endfunction

  // selected lane
  logic [PW-1:0] c_sel, t_sel, w_sel, e_sel, p_sel;
  logic [SW-1:0] ps_sel;
  logic [cwst_pkg::MV_W-1:0] mv_sel;
  assign c_sel  = cur[cmd.sel];
  assign t_sel  = tgt[cmd.sel];
  assign w_sel  = work[cmd.sel];
  assign e_sel  = extra[cmd.sel];
  assign p_sel  = prev[cmd.sel];
  assign ps_sel = pstep[cmd.sel];
  assign mv_sel = mv[cmd.sel];

  logic [cwst_pkg::SPEED_W-1:0]   spd_eff;
  logic [cwst_pkg::MAXSTEP_W:0]   two_m;
  assign spd_eff = (speed == '0) ? cwst_pkg::SPEED_W'(1) : speed;
  assign two_m   = {((max_step == '0) ? cwst_pkg::MAXSTEP_W'(1) : max_step), 1'b0};

  // divider operands
  logic [39:0] path_num;
  logic [23:0] path_den;
  logic [47:0] extra_num;
  logic [PW:0] mv_sum;
  logic [34:0] mv_num;
  logic [44:0] step_num;
  assign path_num  = PATH_K * frame_w;
  assign path_den  = spd_eff * REF_W;
  assign extra_num = path * abs24(t_sel, c_sel);
  assign mv_sum    = {1'b0, e_sel} + {1'b0, abs24(t_sel, w_sel)};
  assign mv_num    = mv_sum * spd_eff;
  assign step_num  = mv_sel * two_m;

  // per-mille scaling: floor(x / 1000) = floor((x >> 3) * RECIP_125 >> 35), exact below 2^35
  logic [31:0] mv_y;
  logic        mv_pend;
  logic [60:0] mv_prod;
  assign mv_prod = mv_y * RECIP_125;

  logic                                 div_start;
  logic [cwst_pkg::DIVIDEND_W-1:0]      dividend;
  logic [cwst_pkg::DIVISOR_W-1:0]       divisor;
  logic                                 div_done;
  logic [cwst_pkg::DIVIDEND_W-1:0]      quotient;

  always_comb begin
    div_start = 1'b0;
    dividend  = '0;
    divisor   = '0;
    unique case (cmd.op)
      cwst_pkg::OP_DIV_PATH: begin
        div_start = 1'b1;
        dividend  = cwst_pkg::DIVIDEND_W'(path_num);
        divisor   = cwst_pkg::DIVISOR_W'(path_den);
      end
      cwst_pkg::OP_DIV_EXTRA: begin
        div_start = 1'b1;
        dividend  = extra_num;
        divisor   = cwst_pkg::DIVISOR_W'(dmax);
      end
      cwst_pkg::OP_DIV_STEP: begin
        div_start = 1'b1;
        dividend  = cwst_pkg::DIVIDEND_W'(step_num);
        divisor   = key;
      end
      default: ;
    endcase
  end

  cwst_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // position step of one lane from the quotient
  logic [cwst_pkg::MV_W-1:0] s_q;
  logic [PW+2:0]             s_sum;
  logic [PW-1:0]             w_step;
  assign s_q   = quotient[cwst_pkg::MV_W-1:0];
  assign s_sum = (PW+3)'(w_sel) + (PW+3)'(s_q);
  always_comb begin
    if (t_sel > w_sel) begin
      w_step = (s_sum > (PW+3)'(cwst_pkg::POS_MAX)) ? cwst_pkg::POS_MAX : s_sum[PW-1:0];
    end else if (t_sel < w_sel) begin
      w_step = ((PW+3)'(w_sel) >= (PW+3)'(s_q)) ? PW'((PW+3)'(w_sel) - (PW+3)'(s_q)) : '0;
    end else begin
      w_step = w_sel;
    end
  end

  // common slowdown key
  logic [cwst_pkg::KEY_W-1:0] key_n;
  always_comb begin
    key_n = cwst_pkg::KEY_W'(two_m);
    if ({mv[0], 1'b0} > key_n) key_n = {mv[0], 1'b0};
    if ({mv[1], 1'b0} > key_n) key_n = {mv[1], 1'b0};
    if (cwst_pkg::KEY_W'(mv[2]) > key_n) key_n = cwst_pkg::KEY_W'(mv[2]);
  end

  // per-axis distances, dmax and snapping
  logic [PW-1:0] gap  [NL];
  logic [PW-1:0] fin  [NL];
  logic          snap [NL];
  logic [PW-1:0] dmax_n;
  always_comb begin
    dmax_n = '0;
    for (int i = 0; i < NL; i++) begin
      gap[i]  = abs24(tgt[i], cur[i]);
      snap[i] = gap[i] < HALF3;
      fin[i]  = snap[i] ? tgt[i] : cur[i];
      if (gap[i] > dmax_n) dmax_n = gap[i];
    end
  end

  function automatic logic [cwst_pkg::IN_W-1:0] clamp_out(input logic [PW-1:0] v);
    clamp_out = (v > PW'(cwst_pkg::OUT_MAX)) ? cwst_pkg::OUT_MAX : v[cwst_pkg::IN_W-1:0];
  endfunction

  // stabilization helpers
  logic [PW:0]   ceil_c, ceil_w;
  logic [SW-1:0] cs0, tmp_n, lim;
  logic          init_nudge, better;
  logic [PW-1:0] c_away, c_toward;
  assign ceil_c     = ceil_px(c_sel);
  assign ceil_w     = ceil_px(w_sel);
  assign cs0        = sat_step(abs25(ceil_px(p_sel), ceil_c));
  assign init_nudge = {1'b0, cs0} == ({1'b0, ps_sel} + (SW+1)'(1));
  assign c_away     = nudge(c_sel, t_sel, SW'(1), 1'b0);
  assign tmp_n      = sat_step(abs25(ceil_w, pos));
  assign better     = abs14(ps_sel, tmp_n) < abs14(ps_sel, cs);
  assign c_toward   = nudge(c_sel, t_sel, abs14(cs, tmp_n), 1'b1);
  assign lim        = (cmd.sel == cwst_pkg::AXIS_W) ? cwst_pkg::LIMIT_W : cwst_pkg::LIMIT_XY;

  assign status.div_done  = div_done || mv_pend;
  assign status.dmax_zero = dmax == '0;
  assign status.loop_go   = (ps_sel > cs) && (abs14(ps_sel, tmp) <= lim) &&
                            (abs24(t_sel, w_sel) > HALF3);
  assign status.ps_eq     = ps_sel == tmp_n;
  assign status.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed     <= cwst_pkg::SPEED_RST;
      max_step  <= cwst_pkg::MAXSTEP_RST;
      frame_w   <= cwst_pkg::FWIDTH_RST;
      seen      <= 1'b0;
      capped    <= 1'b0;
      out_valid <= 1'b0;
      mv_pend   <= 1'b0;
      for (int i = 0; i < NL; i++) begin
        cur[i]   <= '0;
        tgt[i]   <= '0;
        prev[i]  <= '0;
        extra[i] <= '0;
        pstep[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cwst_pkg::REG_SPEED:    speed    <= cfg_data[cwst_pkg::SPEED_W-1:0];
          cwst_pkg::REG_MAX_STEP: max_step <= cfg_data[cwst_pkg::MAXSTEP_W-1:0];
          cwst_pkg::REG_FRAME_W:  frame_w  <= cfg_data[cwst_pkg::FWIDTH_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && (cmd.op != cwst_pkg::OP_FINISH)) out_valid <= 1'b0;

      if (div_start) div_op <= cmd.op;

      mv_pend <= cmd.op == cwst_pkg::OP_DIV_MV;
      if (mv_pend) mv[cmd.sel] <= mv_prod[60:35];

      if (div_done) begin
        unique case (div_op)
          cwst_pkg::OP_DIV_PATH:
            path <= (quotient > cwst_pkg::DIVIDEND_W'(cwst_pkg::POS_MAX)) ?
                    cwst_pkg::POS_MAX : quotient[PW-1:0];
          cwst_pkg::OP_DIV_EXTRA: extra[cmd.sel] <= quotient[PW-1:0];
          cwst_pkg::OP_DIV_STEP:  work[cmd.sel]  <= w_step;
          default: ;
        endcase
      end

      unique case (cmd.op)
        cwst_pkg::OP_LOAD: begin
          tgt[0] <= PW'(in_x);
          tgt[1] <= PW'(in_y);
          tgt[2] <= PW'(in_w);
          if (!seen) begin
            cur[0] <= PW'(in_x);
            cur[1] <= PW'(in_y);
            cur[2] <= PW'(in_w);
          end
          seen   <= 1'b1;
          capped <= 1'b0;
        end
        cwst_pkg::OP_DMAX: dmax <= dmax_n;
        cwst_pkg::OP_ZERO_EXTRA: begin
          for (int i = 0; i < NL; i++) extra[i] <= '0;
        end
        cwst_pkg::OP_WORK_FROM_CUR: begin
          for (int i = 0; i < NL; i++) work[i] <= cur[i];
        end
        cwst_pkg::OP_DIV_MV: mv_y <= mv_num[34:3];
        cwst_pkg::OP_KEY: key <= key_n;
        cwst_pkg::OP_CUR_FROM_WORK: begin
          for (int i = 0; i < NL; i++) cur[i] <= work[i];
        end
        cwst_pkg::OP_ST_INIT: begin
          for (int i = 0; i < NL; i++) work[i] <= cur[i];
          tmp <= cs0;
          pos <= ceil_c;
          if (init_nudge) begin
            cur[cmd.sel] <= c_away;
            cs           <= ps_sel;
          end else begin
            cs <= cs0;
          end
        end
        cwst_pkg::OP_ST_AFTER: begin
          tmp <= tmp_n;
          pos <= ceil_w;
          if (status.ps_eq || better) begin
            cur[cmd.sel] <= c_toward;
            cs           <= tmp_n;
          end
        end
        cwst_pkg::OP_ST_DONE: pstep[cmd.sel] <= cs;
        cwst_pkg::OP_SET_CAP: capped <= 1'b1;
        cwst_pkg::OP_FINISH: begin
          for (int i = 0; i < NL; i++) begin
            prev[i] <= cur[i];
            cur[i]  <= fin[i];
            if (snap[i]) extra[i] <= '0;
          end
          out_x      <= clamp_out(fin[0]);
          out_y      <= clamp_out(fin[1]);
          out_w      <= clamp_out(fin[2]);
          out_capped <= capped;
          out_valid  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/cwst_ctrl.sv
`default_nettype none
module cwst_ctrl #(
  parameter int MAX_REFINE = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cwst_pkg::status_t  status,
  output cwst_pkg::cmd_t          cmd
);

  localparam int NW = $clog2(MAX_REFINE + 1);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_PATH     = 5'd1;
  localparam logic [4:0] S_PATH_W   = 5'd2;
  localparam logic [4:0] S_DMAX     = 5'd3;
  localparam logic [4:0] S_EXT      = 5'd4;
  localparam logic [4:0] S_EXT_W    = 5'd5;
  localparam logic [4:0] S_MAIN     = 5'd6;
  localparam logic [4:0] S_MV       = 5'd7;
  localparam logic [4:0] S_MV_W     = 5'd8;
  localparam logic [4:0] S_KEY      = 5'd9;
  localparam logic [4:0] S_STEP     = 5'd10;
  localparam logic [4:0] S_STEP_W   = 5'd11;
  localparam logic [4:0] S_MAIN_END = 5'd12;
  localparam logic [4:0] S_ST_INIT  = 5'd13;
  localparam logic [4:0] S_ST_TEST  = 5'd14;
  localparam logic [4:0] S_AFTER    = 5'd15;
  localparam logic [4:0] S_ST_DONE  = 5'd16;
  localparam logic [4:0] S_FINAL    = 5'd17;

  logic [4:0]                    state, state_next;
  logic [cwst_pkg::LANE_W-1:0]   lane, lane_next;
  logic [cwst_pkg::LANE_W-1:0]   axis, axis_next;
  logic                          ret_main, ret_main_next;
  logic [NW-1:0]                 n, n_next;
  logic                          lane_phase;

  assign in_ready   = state == S_IDLE;
  // lane-by-lane phases address through lane, stabilization through axis
  assign lane_phase = (state == S_EXT) || (state == S_EXT_W) || (state == S_MV) ||
                      (state == S_MV_W) || (state == S_STEP) || (state == S_STEP_W);
  assign cmd.sel    = lane_phase ? lane : axis;

  always_comb begin
    state_next    = state;
    lane_next     = lane;
    axis_next     = axis;
    ret_main_next = ret_main;
    n_next        = n;
    cmd.op        = cwst_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = cwst_pkg::OP_LOAD;
          state_next = S_PATH;
        end
      end
      S_PATH: begin
        cmd.op     = cwst_pkg::OP_DIV_PATH;
        state_next = S_PATH_W;
      end
      S_PATH_W: if (status.div_done) state_next = S_DMAX;
      S_DMAX: begin
        cmd.op     = cwst_pkg::OP_DMAX;
        lane_next  = cwst_pkg::AXIS_X;
        state_next = S_EXT;
      end
      S_EXT: begin
        if (status.dmax_zero) begin
          cmd.op     = cwst_pkg::OP_ZERO_EXTRA;
          state_next = S_MAIN;
        end else begin
          cmd.op     = cwst_pkg::OP_DIV_EXTRA;
          state_next = S_EXT_W;
        end
      end
      S_EXT_W: begin
        if (status.div_done) begin
          if (lane == cwst_pkg::AXIS_W) begin
            state_next = S_MAIN;
          end else begin
            lane_next  = lane + 2'd1;
            state_next = S_EXT;
          end
        end
      end
      S_MAIN: begin
        cmd.op        = cwst_pkg::OP_WORK_FROM_CUR;
        ret_main_next = 1'b1;
        lane_next     = cwst_pkg::AXIS_X;
        state_next    = S_MV;
      end
      S_MV: begin
        cmd.op     = cwst_pkg::OP_DIV_MV;
        state_next = S_MV_W;
      end
      S_MV_W: begin
        if (status.div_done) begin
          if (lane == cwst_pkg::AXIS_W) begin
            lane_next  = cwst_pkg::AXIS_X;
            state_next = S_KEY;
          end else begin
            lane_next  = lane + 2'd1;
            state_next = S_MV;
          end
        end
      end
      S_KEY: begin
        cmd.op     = cwst_pkg::OP_KEY;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.op     = cwst_pkg::OP_DIV_STEP;
        state_next = S_STEP_W;
      end
      S_STEP_W: begin
        if (status.div_done) begin
          if (lane == cwst_pkg::AXIS_W) begin
            state_next = ret_main ? S_MAIN_END : S_AFTER;
          end else begin
            lane_next  = lane + 2'd1;
            state_next = S_STEP;
          end
        end
      end
      S_MAIN_END: begin
        cmd.op     = cwst_pkg::OP_CUR_FROM_WORK;
        axis_next  = cwst_pkg::AXIS_X;
        state_next = S_ST_INIT;
      end
      S_ST_INIT: begin
        cmd.op     = cwst_pkg::OP_ST_INIT;
        n_next     = '0;
        state_next = S_ST_TEST;
      end
      S_ST_TEST: begin
        priority if (!status.loop_go) begin
          state_next = S_ST_DONE;
        end else if (n >= NW'(MAX_REFINE)) begin
          cmd.op     = cwst_pkg::OP_SET_CAP;
          state_next = S_ST_DONE;
        end else begin
          n_next        = n + NW'(1);
          lane_next     = cwst_pkg::AXIS_X;
          ret_main_next = 1'b0;
          state_next    = S_MV;
        end
      end
      S_AFTER: begin
        cmd.op     = cwst_pkg::OP_ST_AFTER;
        state_next = status.ps_eq ? S_ST_DONE : S_ST_TEST;
      end
      S_ST_DONE: begin
        cmd.op = cwst_pkg::OP_ST_DONE;
        if (axis == cwst_pkg::AXIS_W) begin
          state_next = S_FINAL;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_ST_INIT;
        end
      end
      S_FINAL: begin
        if (!status.out_busy) begin
          cmd.op     = cwst_pkg::OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      lane     <= '0;
      axis     <= '0;
      ret_main <= 1'b0;
      n        <= '0;
    end else begin
      state    <= state_next;
      lane     <= lane_next;
      axis     <= axis_next;
      ret_main <= ret_main_next;
      n        <= n_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/crop_window_smooth_tracker.sv
// channel   dir  beat contents (lowest bit first)
// s_axis    in   tdata: target_x[20:0] target_y[41:21] target_w[62:42] zero[63]
// m_axis    out  tdata: crop_x[20:0] crop_y[41:21] crop_w[62:42] zero[63]; tuser: refine_capped
// cfg       in   cfg_we, cfg_index (0 speed_permille, 1 max_step, 2 frame_width), cfg_data
//
// one frame at a time; variable-divisor quotients share one restoring divider
// the per-mille scaling is a reciprocal multiply
// each refinement trial reruns one full advance
// each axis runs at most MAX_REFINE refinement trials before it is capped
// rst is synchronous: crop state zero, registers at defaults, no beat pending
// a waiting result is held in the output register; the next target is taken meanwhile
`default_nettype none
module crop_window_smooth_tracker #(
  parameter int FRAC_BITS  = 8,
  parameter int MAX_REFINE = 64,
  parameter int REF_WIDTH  = 3840
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // target_x, target_y, target_w, pad
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [63:0]                      s_axis_tdata,
  // crop_x, crop_y, crop_w, pad
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [63:0]                           m_axis_tdata,
  // refine_capped
  output logic [0:0]                            m_axis_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [cwst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cwst_pkg::CFG_DATA_W-1:0]  cfg_data
);

  cwst_pkg::cmd_t    cmd;
  cwst_pkg::status_t status;
  logic [cwst_pkg::IN_W-1:0] out_x, out_y, out_w;
  logic                      out_capped;

  // sequencer: walks path, extras, the main advance and per-axis refinement
  cwst_ctrl #(
    .MAX_REFINE (MAX_REFINE)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // crop state, divider and output register
  cwst_dp #(
    .FRAC_BITS (FRAC_BITS),
    .REF_WIDTH (REF_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_x       (s_axis_tdata[20:0]),
    .in_y       (s_axis_tdata[41:21]),
    .in_w       (s_axis_tdata[62:42]),
    .cmd        (cmd),
    .status     (status),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_w      (out_w),
    .out_capped (out_capped),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, out_w, out_y, out_x};
  assign m_axis_tuser = out_capped;

endmodule
`default_nettype wire

FILE: design/cwst_checker.sv
`default_nettype none
`include "crop_window_smooth_tracker_assert.svh"
module cwst_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // a stalled result stays offered
  `CWST_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  // and keeps its payload
  `CWST_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))
  // a frame is being worked on right after a target is taken
  `CWST_ASSERT_NXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // reset leaves the block ready and with nothing to deliver
  `CWST_ASSERT_RST_NXT(a_reset_state, rst, s_axis_tready && !m_axis_tvalid)

endmodule

bind crop_window_smooth_tracker cwst_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
